// ===== rtl/fmvt_pkg.sv =====
`default_nettype none
package fmvt_pkg;

  localparam int CHANNELS       = 8;
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_BITS      = COEF_FRAC_BITS + 2;
  localparam int CH_BITS        = $clog2(CHANNELS);
  localparam int PROD_BITS      = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_BITS       = PROD_BITS + CH_BITS;
  localparam int SHIFT_BITS     = ACC_BITS - COEF_FRAC_BITS;
  localparam int PIPE_DEPTH     = 4;

  localparam logic MODE_TRANSFORM = 1'b0;
  localparam logic MODE_LOAD      = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;
  typedef logic        [CH_BITS-1:0]     ch_idx_t;

  typedef sample_t   sample_vec_t [CHANNELS];
  typedef coef_t     coef_row_t   [CHANNELS];
  typedef coef_row_t coef_mat_t   [CHANNELS];
  typedef acc_t      acc_vec_t    [CHANNELS];

  typedef struct packed {
    logic    en;
    ch_idx_t row;
    ch_idx_t col;
    coef_t   value;
  } coef_wr_t;

endpackage
`default_nettype wire

// ===== rtl/feedback_matrix_vector_transform.sv =====
// channel | direction | handshake          | fields
// in      | input     | in_valid/in_stall  | mode, coef_row, coef_col, coef_value, sample_0..7
// out     | output    | out_valid/out_stall| out_0..7
//
// One word accepted per cycle while the output is not stalled; a transform word
// yields its result through the multiply stage, three adder levels and the output register.
// A load word writes the coefficient table at its accept edge and yields nothing.
// rst clears the table and all valid flags. The whole pipeline holds while the
// output word is stalled; in_stall is high exactly then.
`default_nettype none
module feedback_matrix_vector_transform
  import fmvt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 mode,
  input  wire logic [2:0]           coef_row,
  input  wire logic [2:0]           coef_col,
  input  wire logic signed [17:0]   coef_value,
  input  wire logic signed [23:0]   sample_0,
  input  wire logic signed [23:0]   sample_1,
  input  wire logic signed [23:0]   sample_2,
  input  wire logic signed [23:0]   sample_3,
  input  wire logic signed [23:0]   sample_4,
  input  wire logic signed [23:0]   sample_5,
  input  wire logic signed [23:0]   sample_6,
  input  wire logic signed [23:0]   sample_7,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [23:0]        out_0,
  output logic signed [23:0]        out_1,
  output logic signed [23:0]        out_2,
  output logic signed [23:0]        out_3,
  output logic signed [23:0]        out_4,
  output logic signed [23:0]        out_5,
  output logic signed [23:0]        out_6,
  output logic signed [23:0]        out_7
);

  logic        adv;
  logic        accept;
  coef_wr_t    wr;
  coef_mat_t   coefs;
  sample_vec_t samples;
  acc_vec_t    sums;
  sample_vec_t outs;

  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  assign wr.en    = accept && (mode == MODE_LOAD);
  assign wr.row   = coef_row;
  assign wr.col   = coef_col;
  assign wr.value = coef_value;

  assign samples[0] = sample_0;
  assign samples[1] = sample_1;
  assign samples[2] = sample_2;
  assign samples[3] = sample_3;
  assign samples[4] = sample_4;
  assign samples[5] = sample_5;
  assign samples[6] = sample_6;
  assign samples[7] = sample_7;

  fmvt_coef_table u_table (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .coefs (coefs)
  );

  for (genvar j = 0; j < CHANNELS; j++) begin : g_lane
    fmvt_lane u_lane (
      .clk       (clk),
      .adv       (adv),
      .row_coefs (coefs[j]),
      .samples   (samples),
      .sum       (sums[j])
    );
  end

  fmvt_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .item_in   (in_valid && (mode == MODE_TRANSFORM)),
    .sums      (sums),
    .out_stall (out_stall),
    .adv       (adv),
    .out_valid (out_valid),
    .outs      (outs)
  );

  assign out_0 = outs[0];
  assign out_1 = outs[1];
  assign out_2 = outs[2];
  assign out_3 = outs[3];
  assign out_4 = outs[4];
  assign out_5 = outs[5];
  assign out_6 = outs[6];
  assign out_7 = outs[7];

endmodule
`default_nettype wire

// ===== rtl/fmvt_coef_table.sv =====
`default_nettype none
module fmvt_coef_table
  import fmvt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire coef_wr_t  wr,
  output coef_mat_t      coefs
);

  coef_mat_t table_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < CHANNELS; r++) begin
        for (int c = 0; c < CHANNELS; c++) begin
          table_q[r][c] <= '0;
        end
      end
    end else if (wr.en) begin
      table_q[wr.row][wr.col] <= wr.value;
    end
  end

  assign coefs = table_q;

endmodule
`default_nettype wire

// ===== rtl/fmvt_lane.sv =====
`default_nettype none
module fmvt_lane
  import fmvt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        adv,
  input  wire coef_row_t   row_coefs,
  input  wire sample_vec_t samples,
  output acc_t             sum
);

  prod_t prod  [CHANNELS];
  acc_t  lvl1  [CHANNELS/2];
  acc_t  lvl2  [CHANNELS/4];
  acc_t  total;

  // multiply, then three registered adder levels
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < CHANNELS; i++) begin
        prod[i] <= prod_t'(row_coefs[i]) * prod_t'(samples[i]);
      end
      for (int i = 0; i < CHANNELS/2; i++) begin
        lvl1[i] <= acc_t'(prod[2*i]) + acc_t'(prod[2*i+1]);
      end
      for (int i = 0; i < CHANNELS/4; i++) begin
        lvl2[i] <= lvl1[2*i] + lvl1[2*i+1];
      end
      total <= lvl2[0] + lvl2[1];
    end
  end

  assign sum = total;

endmodule
`default_nettype wire

// ===== rtl/fmvt_merge.sv =====
`default_nettype none
module fmvt_merge
  import fmvt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_in,
  input  wire acc_vec_t sums,
  input  wire logic     out_stall,
  output logic          adv,
  output logic          out_valid,
  output sample_vec_t   outs
);

  logic [PIPE_DEPTH-1:0] stage_valid;
  sample_vec_t           outs_next;

  assign adv = !out_valid || !out_stall;

  always_comb begin
    logic signed [SHIFT_BITS-1:0] q;
    for (int j = 0; j < CHANNELS; j++) begin
      // floor by arithmetic shift, then clamp
      q = $signed(sums[j][ACC_BITS-1:COEF_FRAC_BITS]);
      if (q[SHIFT_BITS-1:SAMPLE_BITS-1] == '0 || q[SHIFT_BITS-1:SAMPLE_BITS-1] == '1) begin
        outs_next[j] = q[SAMPLE_BITS-1:0];
      end else if (q[SHIFT_BITS-1]) begin
        outs_next[j] = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
        outs_next[j] = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      out_valid   <= 1'b0;
    end else if (adv) begin
      stage_valid <= {stage_valid[PIPE_DEPTH-2:0], item_in};
      out_valid   <= stage_valid[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      outs <= outs_next;
    end
  end

endmodule
`default_nettype wire
